// ----- sv/bridge_adc_serial_reader_averager_defines.svh -----
// assertion macros for the bridge adc serial reader averager checker
// expects clk and rst_n in the scope where a macro is used
`ifndef BRIDGE_ADC_SERIAL_READER_AVERAGER_DEFINES_SVH
`define BRIDGE_ADC_SERIAL_READER_AVERAGER_DEFINES_SVH

// same-cycle implication
`define BADC_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("badc check failed");

// next-cycle implication
`define BADC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("badc check failed");

`endif

// ----- sv/badc_pkg.sv -----
// shared types and constants of the bridge adc serial reader averager
// no dependencies
package badc_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int RAW_W      = 24;
    localparam int NET_W      = 25;
    localparam int SUM_W      = 32;
    localparam int DIV_W      = 32;
    localparam int CNT_W      = 8;
    localparam int DIV_STEP_W = $clog2(DIV_W);
    localparam int EXT_W      = 33;

    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_SELECT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_AVERAGE_CNT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TARE_OFFSET  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_PERIOD  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_POWER_DOWN   = 3'd4;

    localparam logic [1:0] GAIN_CH_B_32 = 2'd1;
    localparam logic [1:0] GAIN_CH_A_64 = 2'd2;

    localparam logic [1:0] EXTRA_ONE   = 2'd1;
    localparam logic [1:0] EXTRA_TWO   = 2'd2;
    localparam logic [1:0] EXTRA_THREE = 2'd3;

    localparam logic signed [EXT_W-1:0] RAW_MAX = 33'sd8388607;
    localparam logic signed [EXT_W-1:0] RAW_MIN = -33'sd8388608;

    typedef enum logic [1:0] {
        PH_WAIT,
        PH_HIGH,
        PH_LOW
    } phase_t;

    typedef enum logic {
        CORE_RUN,
        CORE_DIV
    } core_state_t;

    typedef struct packed {
        logic                    sck_level;
        logic                    raw_valid;
        logic signed [RAW_W-1:0] raw_sample;
        logic                    net_valid;
        logic signed [NET_W-1:0] net_value;
    } result_t;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [CNT_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             busy;
        logic [DIV_W-1:0] quotient;
    } div_rsp_t;

endpackage

// ----- sv/badc_queue.sv -----
// two-entry queue used at the input and at the result side
// no dependencies
module badc_queue #(
    parameter int WIDTH = 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    logic [WIDTH-1:0] entry_reg [2];
    logic             wr_ptr_reg;
    logic             wr_ptr_next;
    logic             rd_ptr_reg;
    logic             rd_ptr_next;
    logic [1:0]       count_reg;
    logic [1:0]       count_next;
    logic             push_ok;
    logic             pop_ok;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign push_ok = push && !full;
    assign pop_ok  = pop && !empty;
    assign rdata   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push_ok;
        rd_ptr_next = rd_ptr_reg ^ pop_ok;
        count_next  = count_reg;
        if (push_ok && !pop_ok)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop_ok && !push_ok)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            entry_reg[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- sv/badc_divider.sv -----
// restoring unsigned divider, one quotient bit per cycle
// depends on badc_pkg
module badc_divider (
    input  logic              clk,
    input  logic              rst_n,
    input  badc_pkg::div_req_t req,
    output badc_pkg::div_rsp_t rsp
);

    logic                              busy_reg;
    logic                              busy_next;
    logic [badc_pkg::DIV_STEP_W-1:0]   step_reg;
    logic [badc_pkg::DIV_STEP_W-1:0]   step_next;
    logic [badc_pkg::DIV_W-1:0]        quot_reg;
    logic [badc_pkg::DIV_W-1:0]        quot_next;
    logic [badc_pkg::CNT_W-1:0]        rem_reg;
    logic [badc_pkg::CNT_W-1:0]        rem_next;
    logic [badc_pkg::CNT_W-1:0]        divisor_reg;
    logic [badc_pkg::CNT_W-1:0]        divisor_next;
    logic [badc_pkg::CNT_W:0]          trial;
    logic                              fits;

    assign trial = {rem_reg, quot_reg[badc_pkg::DIV_W-1]};
    assign fits  = (trial >= {1'b0, divisor_reg});

    always_comb
    begin
        busy_next    = busy_reg;
        step_next    = step_reg;
        quot_next    = quot_reg;
        rem_next     = rem_reg;
        divisor_next = divisor_reg;
        if (req.start)
        begin
            busy_next    = 1'b1;
            step_next    = badc_pkg::DIV_STEP_W'(badc_pkg::DIV_W - 1);
            quot_next    = req.dividend;
            rem_next     = '0;
            divisor_next = req.divisor;
        end
        else if (busy_reg)
        begin
            quot_next = {quot_reg[badc_pkg::DIV_W-2:0], fits};
            rem_next  = fits ? badc_pkg::CNT_W'(trial - {1'b0, divisor_reg})
                             : trial[badc_pkg::CNT_W-1:0];
            step_next = step_reg - 1'b1;
            if (step_reg == '0)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b0;
            step_reg    <= '0;
            quot_reg    <= '0;
            rem_reg     <= '0;
            divisor_reg <= '0;
        end
        else
        begin
            busy_reg    <= busy_next;
            step_reg    <= step_next;
            quot_reg    <= quot_next;
            rem_reg     <= rem_next;
            divisor_reg <= divisor_next;
        end
    end

    assign rsp.busy     = busy_reg;
    assign rsp.quotient = quot_reg;

endmodule

// ----- sv/badc_core.sv -----
// serial link sequencer, accumulator and configuration registers
// depends on badc_pkg; drives badc_divider through div_req_t
module badc_core #(
    parameter int SAMPLE_BITS = 24
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [badc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [badc_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              in_empty,
    input  logic                              in_data,
    output logic                              in_pop,
    input  logic                              out_full,
    output logic                              out_push,
    output badc_pkg::result_t                 out_data,
    output badc_pkg::div_req_t                div_req,
    input  badc_pkg::div_rsp_t                div_rsp
);

    localparam int PW = $clog2(SAMPLE_BITS + 4);

    logic [1:0]                           gain_reg;
    logic [badc_pkg::CNT_W-1:0]           avg_cnt_reg;
    logic signed [badc_pkg::RAW_W-1:0]    tare_reg;
    logic [7:0]                           half_period_reg;
    logic                                 power_down_reg;

    badc_pkg::core_state_t                state_reg;
    badc_pkg::core_state_t                state_next;
    badc_pkg::phase_t                     phase_reg;
    badc_pkg::phase_t                     phase_next;
    logic [7:0]                           half_reg;
    logic [7:0]                           half_next;
    logic [PW-1:0]                        pulse_reg;
    logic [PW-1:0]                        pulse_next;
    logic [SAMPLE_BITS-1:0]               shift_reg;
    logic [SAMPLE_BITS-1:0]               shift_next;
    logic signed [badc_pkg::SUM_W-1:0]    sum_reg;
    logic signed [badc_pkg::SUM_W-1:0]    sum_next;
    logic [badc_pkg::CNT_W-1:0]           samples_reg;
    logic [badc_pkg::CNT_W-1:0]           samples_next;
    logic signed [badc_pkg::RAW_W-1:0]    last_raw_reg;
    logic signed [badc_pkg::RAW_W-1:0]    last_raw_next;
    logic signed [badc_pkg::NET_W-1:0]    last_net_reg;
    logic signed [badc_pkg::NET_W-1:0]    last_net_next;
    logic                                 neg_reg;
    logic                                 neg_next;

    logic [7:0]                           hp;
    logic [badc_pkg::CNT_W-1:0]           cnt;
    logic [1:0]                           extra;
    logic [PW-1:0]                        total;
    logic [7:0]                           half_inc;
    logic                                 half_done;
    logic [PW-1:0]                        pulse_inc;
    logic [badc_pkg::CNT_W-1:0]           samples_inc;
    logic signed [badc_pkg::EXT_W-1:0]    raw_ext;
    logic signed [badc_pkg::RAW_W-1:0]    raw_sat;
    logic signed [badc_pkg::SUM_W-1:0]    sum_add;
    logic signed [badc_pkg::SUM_W-1:0]    avg;
    logic signed [badc_pkg::SUM_W-1:0]    net_full;
    logic signed [badc_pkg::NET_W-1:0]    net;
    logic                                 tick_sck;
    logic                                 tick_raw_valid;
    logic                                 go_div;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg        <= 2'd0;
            avg_cnt_reg     <= 8'd1;
            tare_reg        <= '0;
            half_period_reg <= 8'd1;
            power_down_reg  <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                badc_pkg::CFG_GAIN_SELECT: gain_reg        <= cfg_data[1:0];
                badc_pkg::CFG_AVERAGE_CNT: avg_cnt_reg     <= cfg_data[7:0];
                badc_pkg::CFG_TARE_OFFSET: tare_reg        <= signed'(cfg_data);
                badc_pkg::CFG_HALF_PERIOD: half_period_reg <= cfg_data[7:0];
                badc_pkg::CFG_POWER_DOWN:  power_down_reg  <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    assign hp  = (half_period_reg == 8'd0) ? 8'd1 : half_period_reg;
    assign cnt = (avg_cnt_reg == 8'd0) ? 8'd1 : avg_cnt_reg;

    always_comb
    begin
        unique case (gain_reg)
            badc_pkg::GAIN_CH_B_32: extra = badc_pkg::EXTRA_TWO;
            badc_pkg::GAIN_CH_A_64: extra = badc_pkg::EXTRA_THREE;
            default:                extra = badc_pkg::EXTRA_ONE;
        endcase
    end

    assign total       = PW'(SAMPLE_BITS) + PW'(extra);
    assign half_inc    = half_reg + 8'd1;
    assign half_done   = (half_inc >= hp) || (half_inc == 8'd0);
    assign pulse_inc   = pulse_reg + PW'(1);
    assign samples_inc = samples_reg + 8'd1;

    // sign-extend the captured word, then clamp to 24 bits
    assign raw_ext = badc_pkg::EXT_W'(signed'(shift_reg));
    always_comb
    begin
        priority if (raw_ext > badc_pkg::RAW_MAX)
        begin
            raw_sat = badc_pkg::RAW_MAX[badc_pkg::RAW_W-1:0];
        end
        else if (raw_ext < badc_pkg::RAW_MIN)
        begin
            raw_sat = badc_pkg::RAW_MIN[badc_pkg::RAW_W-1:0];
        end
        else
        begin
            raw_sat = raw_ext[badc_pkg::RAW_W-1:0];
        end
    end

    assign sum_add  = sum_reg + badc_pkg::SUM_W'(raw_sat);
    assign avg      = neg_reg ? -signed'(div_rsp.quotient) : signed'(div_rsp.quotient);
    assign net_full = avg - badc_pkg::SUM_W'(tare_reg);
    assign net      = net_full[badc_pkg::NET_W-1:0];

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        half_next      = half_reg;
        pulse_next     = pulse_reg;
        shift_next     = shift_reg;
        sum_next       = sum_reg;
        samples_next   = samples_reg;
        last_raw_next  = last_raw_reg;
        last_net_next  = last_net_reg;
        neg_next       = neg_reg;
        tick_sck       = 1'b0;
        tick_raw_valid = 1'b0;
        go_div         = 1'b0;
        in_pop         = 1'b0;
        out_push       = 1'b0;
        out_data       = '0;
        div_req.start    = 1'b0;
        div_req.dividend = sum_add[badc_pkg::SUM_W-1] ? badc_pkg::DIV_W'(-sum_add)
                                                      : badc_pkg::DIV_W'(sum_add);
        div_req.divisor  = cnt;

        unique case (state_reg)
            badc_pkg::CORE_RUN:
            begin
                if (!in_empty && !out_full)
                begin
                    in_pop = 1'b1;
                    if (power_down_reg)
                    begin
                        tick_sck   = 1'b1;
                        phase_next = badc_pkg::PH_WAIT;
                        half_next  = '0;
                        pulse_next = '0;
                        shift_next = '0;
                    end
                    else
                    begin
                        unique case (phase_reg)
                            badc_pkg::PH_HIGH:
                            begin
                                tick_sck  = 1'b1;
                                half_next = half_inc;
                                if (half_done)
                                begin
                                    if (pulse_reg < PW'(SAMPLE_BITS))
                                    begin
                                        shift_next = {shift_reg[SAMPLE_BITS-2:0], in_data};
                                    end
                                    half_next  = '0;
                                    phase_next = badc_pkg::PH_LOW;
                                end
                            end
                            badc_pkg::PH_LOW:
                            begin
                                half_next = half_inc;
                                if (half_done)
                                begin
                                    half_next  = '0;
                                    pulse_next = pulse_inc;
                                    if (pulse_inc >= total)
                                    begin
                                        last_raw_next  = raw_sat;
                                        tick_raw_valid = 1'b1;
                                        if ((samples_inc >= cnt) || (samples_inc == 8'd0))
                                        begin
                                            div_req.start = 1'b1;
                                            go_div        = 1'b1;
                                            neg_next      = sum_add[badc_pkg::SUM_W-1];
                                            sum_next      = '0;
                                            samples_next  = '0;
                                        end
                                        else
                                        begin
                                            sum_next     = sum_add;
                                            samples_next = samples_inc;
                                        end
                                        phase_next = badc_pkg::PH_WAIT;
                                        half_next  = '0;
                                        pulse_next = '0;
                                        shift_next = '0;
                                    end
                                    else
                                    begin
                                        phase_next = badc_pkg::PH_HIGH;
                                    end
                                end
                            end
                            default:
                            begin
                                phase_next = in_data ? badc_pkg::PH_WAIT : badc_pkg::PH_HIGH;
                                half_next  = '0;
                                pulse_next = '0;
                                shift_next = '0;
                            end
                        endcase
                    end
                    if (go_div)
                    begin
                        state_next = badc_pkg::CORE_DIV;
                    end
                    else
                    begin
                        out_push            = 1'b1;
                        out_data.sck_level  = tick_sck;
                        out_data.raw_valid  = tick_raw_valid;
                        out_data.raw_sample = last_raw_next;
                        out_data.net_valid  = 1'b0;
                        out_data.net_value  = last_net_reg;
                    end
                end
            end
            badc_pkg::CORE_DIV:
            begin
                // averaging tick: result leaves once the quotient is in and the result queue has room
                if (!div_rsp.busy && !out_full)
                begin
                    out_push            = 1'b1;
                    last_net_next       = net;
                    out_data.sck_level  = 1'b0;
                    out_data.raw_valid  = 1'b1;
                    out_data.raw_sample = last_raw_reg;
                    out_data.net_valid  = 1'b1;
                    out_data.net_value  = net;
                    state_next          = badc_pkg::CORE_RUN;
                end
            end
            default:
            begin
                state_next = badc_pkg::CORE_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= badc_pkg::CORE_RUN;
            phase_reg    <= badc_pkg::PH_WAIT;
            half_reg     <= '0;
            pulse_reg    <= '0;
            shift_reg    <= '0;
            sum_reg      <= '0;
            samples_reg  <= '0;
            last_raw_reg <= '0;
            last_net_reg <= '0;
            neg_reg      <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            phase_reg    <= phase_next;
            half_reg     <= half_next;
            pulse_reg    <= pulse_next;
            shift_reg    <= shift_next;
            sum_reg      <= sum_next;
            samples_reg  <= samples_next;
            last_raw_reg <= last_raw_next;
            last_net_reg <= last_net_next;
            neg_reg      <= neg_next;
        end
    end

endmodule

// ----- sv/bridge_adc_serial_reader_averager.sv -----
// top level of the bridge adc serial reader averager
// depends on badc_pkg, badc_queue, badc_divider, badc_core
//
// channel   | handshake            | payload
// ----------+----------------------+---------------------------------------------
// tick in   | push / full          | dout_level
// result    | empty / pop          | sck_level raw_valid raw_sample net_valid net_value
// config    | cfg_valid / cfg_ready| cfg_index cfg_data
//
// one cycle per tick in steady flow; the tick that closes an average holds the core in its
// divide state while the 32-step divider runs, and its result is pushed once the quotient is in
// reset restores every control register and counter at once (queue entries are not cleared), no clearing pass
// input and result queues hold two transactions each, so either side may stall
// cfg_ready is always high; writes must come while no tick is in flight, which the block does not enforce
module bridge_adc_serial_reader_averager #(
    parameter int SAMPLE_BITS = 24
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic                              dout_level,
    output logic                              empty,
    input  logic                              pop,
    output logic                              sck_level,
    output logic                              raw_valid,
    output logic signed [badc_pkg::RAW_W-1:0] raw_sample,
    output logic                              net_valid,
    output logic signed [badc_pkg::NET_W-1:0] net_value,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [badc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [badc_pkg::CFG_DATA_W-1:0]   cfg_data
);

    logic                 in_empty;
    logic                 in_data;
    logic                 in_pop;
    logic                 out_full;
    logic                 out_push;
    badc_pkg::result_t    out_wdata;
    badc_pkg::result_t    out_rdata;
    badc_pkg::div_req_t   div_req;
    badc_pkg::div_rsp_t   div_rsp;

    badc_queue #(
        .WIDTH (1)
    ) u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (dout_level),
        .full  (full),
        .pop   (in_pop),
        .rdata (in_data),
        .empty (in_empty)
    );

    badc_core #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_empty  (in_empty),
        .in_data   (in_data),
        .in_pop    (in_pop),
        .out_full  (out_full),
        .out_push  (out_push),
        .out_data  (out_wdata),
        .div_req   (div_req),
        .div_rsp   (div_rsp)
    );

    badc_divider u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    badc_queue #(
        .WIDTH ($bits(badc_pkg::result_t))
    ) u_result (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (out_push),
        .wdata (out_wdata),
        .full  (out_full),
        .pop   (pop),
        .rdata (out_rdata),
        .empty (empty)
    );

    assign sck_level  = out_rdata.sck_level;
    assign raw_valid  = out_rdata.raw_valid;
    assign raw_sample = out_rdata.raw_sample;
    assign net_valid  = out_rdata.net_valid;
    assign net_value  = out_rdata.net_value;

endmodule

// ----- sv/badc_checker.sv -----
// port-level checker for the bridge adc serial reader averager, with its bind
// depends on badc_pkg and bridge_adc_serial_reader_averager_defines.svh
`include "bridge_adc_serial_reader_averager_defines.svh"

module badc_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              empty,
    input logic                              pop,
    input logic                              sck_level,
    input logic                              raw_valid,
    input logic signed [badc_pkg::RAW_W-1:0] raw_sample,
    input logic                              net_valid,
    input logic signed [badc_pkg::NET_W-1:0] net_value
);

    `BADC_ASSERT_NEXT(a_result_stays, !empty && !pop, !empty)
    `BADC_ASSERT_NEXT(a_result_holds, !empty && !pop, $stable(raw_sample) && $stable(net_value))
    `BADC_ASSERT_SAME(a_net_with_raw, !empty && net_valid, raw_valid)
    `BADC_ASSERT_SAME(a_raw_on_low_clk, !empty && raw_valid, !sck_level)

endmodule

bind bridge_adc_serial_reader_averager badc_checker u_badc_checker (.*);
